// ===== sv/stable_counting_sort_macros.svh =====
// ----------------------------------------------------------------------------
// Stable counting sort assertion macros
// Shared concurrent assertion forms used by the sorter's modules.
// ----------------------------------------------------------------------------
`ifndef STABLE_COUNTING_SORT_MACROS_SVH
`define STABLE_COUNTING_SORT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable counting sort package
// Widths, payload structs and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int KEY_W      = 6;
   localparam int PAYLOAD_W  = 64;
   localparam int RANGE_W    = 7;
   localparam int MAX_ITEMS  = 64;
   localparam int MAX_KEYS   = 1 << KEY_W;
   localparam int ITEM_IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
   localparam int PFX_W      = KEY_W + 1;

   localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(64);

   typedef struct packed {
      logic [KEY_W-1:0]     sort_key;
      logic [PAYLOAD_W-1:0] payload;
      logic                 batch_last;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]     out_key;
      logic [PAYLOAD_W-1:0] out_payload;
      logic                 out_last;
      logic                 bad_key_seen;
   } rsp_type;

   // Which pass owns the count memory ports.
   typedef enum logic [1:0] {
      CNT_SRC_LOAD,
      CNT_SRC_PFX,
      CNT_SRC_PLACE
   } cnt_src_type;

   typedef struct packed {
      logic        item_accept;
      cnt_src_type cnt_src;
      logic        pfx_start;
      logic        pfx_run;
      logic        place_item_rd;
      logic        place_wr;
      logic        emit_rd;
      logic        emit_load;
      logic        clear_batch;
   } cmd_type;

   typedef struct packed {
      logic held_zero;
      logic pfx_done;
      logic place_last;
      logic emit_last;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== sv/scs_datapath.sv =====
// ----------------------------------------------------------------------------
// Stable counting sort datapath
// Item store, per-key count memory, sorted store and the result register.
// ----------------------------------------------------------------------------
`include "stable_counting_sort_macros.svh"

module scs_datapath import scs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [RANGE_W-1:0] csr_wr_data,
   input  req_type            req_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  cmd_type            cmd,
   output sts_type            sts
);

   logic [RANGE_W-1:0]    range_ff;
   logic [RANGE_W-1:0]    eff_range;
   logic                  key_bad;
   logic                  item_store;
   logic [CNT_W-1:0]      held_ff;
   logic [CNT_W-1:0]      last_idx;
   logic                  key_error_ff;

   logic [KEY_W-1:0]      item_key_mem [MAX_ITEMS];
   logic [PAYLOAD_W-1:0]  item_pay_mem [MAX_ITEMS];
   logic [KEY_W-1:0]      item_key_rd_ff;
   logic [PAYLOAD_W-1:0]  item_pay_rd_ff;

   logic [CNT_W-1:0]      cnt_mem [MAX_KEYS];
   logic [MAX_KEYS-1:0]   cnt_vld_ff;
   logic [CNT_W-1:0]      cnt_rdata_ff;
   logic                  cnt_rvld_ff;
   logic [CNT_W-1:0]      cnt_rval;
   logic [KEY_W-1:0]      cnt_raddr;
   logic                  cnt_we;
   logic [KEY_W-1:0]      cnt_waddr;
   logic [CNT_W-1:0]      cnt_wdata;

   logic                  s1_vld_ff;
   logic [KEY_W-1:0]      s1_key_ff;
   logic                  fwd_vld_ff;
   logic [KEY_W-1:0]      fwd_key_ff;
   logic [CNT_W-1:0]      fwd_val_ff;
   logic [CNT_W-1:0]      s1_old;
   logic [CNT_W-1:0]      s1_new;

   logic [PFX_W-1:0]      pfx_ff;
   logic                  pfx_rd_vld_ff;
   logic [KEY_W-1:0]      pfx_waddr_ff;
   logic [CNT_W-1:0]      acc_ff;

   logic [ITEM_IDX_W-1:0] plc_ff;
   logic [ITEM_IDX_W-1:0] emit_ff;

   logic [KEY_W-1:0]      sort_key_mem [MAX_ITEMS];
   logic [PAYLOAD_W-1:0]  sort_pay_mem [MAX_ITEMS];
   logic [KEY_W-1:0]      sort_key_rd_ff;
   logic [PAYLOAD_W-1:0]  sort_pay_rd_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   // Key check and admission.
   always_comb begin
      eff_range  = (range_ff > RANGE_W'(MAX_KEYS)) ? RANGE_W'(MAX_KEYS) : range_ff;
      key_bad    = RANGE_W'(req_data.sort_key) >= eff_range;
      item_store = cmd.item_accept && !key_bad && (held_ff < CNT_W'(MAX_ITEMS));
      last_idx   = held_ff - CNT_W'(1);
   end

   // A count entry that was not written in this batch reads as zero.
   assign cnt_rval = cnt_rvld_ff ? cnt_rdata_ff : '0;

   // A count write is not yet visible to a read issued in the same cycle.
   assign s1_old = (fwd_vld_ff && (fwd_key_ff == s1_key_ff)) ? fwd_val_ff : cnt_rval;
   assign s1_new = s1_old + CNT_W'(1);

   always_comb begin
      cnt_raddr = req_data.sort_key;
      cnt_we    = 1'b0;
      cnt_waddr = s1_key_ff;
      cnt_wdata = s1_new;
      case (cmd.cnt_src)
         CNT_SRC_LOAD: begin
            cnt_we = s1_vld_ff;
         end
         CNT_SRC_PFX: begin
            cnt_raddr = pfx_ff[KEY_W-1:0];
            cnt_we    = pfx_rd_vld_ff;
            cnt_waddr = pfx_waddr_ff;
            cnt_wdata = acc_ff;
         end
         CNT_SRC_PLACE: begin
            cnt_raddr = item_key_rd_ff;
            cnt_we    = cmd.place_wr;
            cnt_waddr = item_key_rd_ff;
            cnt_wdata = cnt_rval + CNT_W'(1);
         end
         default: begin
            cnt_we = 1'b0;
         end
      endcase
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (item_store) begin
         item_key_mem[held_ff[ITEM_IDX_W-1:0]] <= req_data.sort_key;
         item_pay_mem[held_ff[ITEM_IDX_W-1:0]] <= req_data.payload;
      end
      if (cmd.place_item_rd) begin
         item_key_rd_ff <= item_key_mem[plc_ff];
         item_pay_rd_ff <= item_pay_mem[plc_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.place_wr) begin
         sort_key_mem[cnt_rval[ITEM_IDX_W-1:0]] <= item_key_rd_ff;
         sort_pay_mem[cnt_rval[ITEM_IDX_W-1:0]] <= item_pay_rd_ff;
      end
      if (cmd.emit_rd) begin
         sort_key_rd_ff <= sort_key_mem[emit_ff];
         sort_pay_rd_ff <= sort_pay_mem[emit_ff];
      end
   end

   // Count valid bits and batch state.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_batch) begin
         cnt_vld_ff   <= '0;
         held_ff      <= '0;
         key_error_ff <= 1'b0;
         plc_ff       <= '0;
         emit_ff      <= '0;
      end else begin
         if (cnt_we) begin
            cnt_vld_ff[cnt_waddr] <= 1'b1;
         end
         if (item_store) begin
            held_ff <= held_ff + CNT_W'(1);
         end
         if (cmd.item_accept && key_bad) begin
            key_error_ff <= 1'b1;
         end
         if (cmd.place_wr) begin
            plc_ff <= plc_ff + ITEM_IDX_W'(1);
         end
         if (cmd.emit_load) begin
            emit_ff <= emit_ff + ITEM_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_rvld_ff <= cnt_vld_ff[cnt_raddr];
      s1_key_ff   <= req_data.sort_key;
      fwd_key_ff  <= s1_key_ff;
      fwd_val_ff  <= s1_new;
      if (reset) begin
         range_ff   <= RANGE_RESET;
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            range_ff <= csr_wr_data;
         end
         s1_vld_ff  <= item_store;
         fwd_vld_ff <= s1_vld_ff;
      end
   end

   // Exclusive prefix sum over the count memory.
   always_ff @(posedge clock) begin
      pfx_waddr_ff <= pfx_ff[KEY_W-1:0];
      if (reset || cmd.pfx_start) begin
         pfx_ff        <= '0;
         pfx_rd_vld_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         if (pfx_rd_vld_ff) begin
            acc_ff <= acc_ff + cnt_rval;
         end
         if (cmd.pfx_run) begin
            pfx_ff        <= pfx_ff + PFX_W'(1);
            pfx_rd_vld_ff <= pfx_ff < PFX_W'(MAX_KEYS);
         end else begin
            pfx_rd_vld_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_data_ff.out_key      <= sort_key_rd_ff;
         rsp_data_ff.out_payload  <= sort_pay_rd_ff;
         rsp_data_ff.out_last     <= CNT_W'(emit_ff) == last_idx;
         rsp_data_ff.bad_key_seen <= key_error_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sts.held_zero  = held_ff == '0;
      sts.pfx_done   = pfx_ff == PFX_W'(MAX_KEYS);
      sts.place_last = CNT_W'(plc_ff) == last_idx;
      sts.emit_last  = CNT_W'(emit_ff) == last_idx;
      sts.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   `SCS_ASSERT_IMPLIES(a_pfx_bound, clock, reset, pfx_rd_vld_ff, acc_ff <= held_ff,
      "prefix sum exceeds items held")
   `SCS_ASSERT_IMPLIES(a_place_pos, clock, reset, cmd.place_wr, cnt_rval < held_ff,
      "placement position out of range")
   `SCS_ASSERT_NEXT(a_stage1, clock, reset, item_store,
      s1_vld_ff && (s1_key_ff == $past(req_data.sort_key)), "count update lost")

endmodule

// ===== sv/scs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stable counting sort controller
// Sequences loading, prefix sum, placement and emission of one batch.
// ----------------------------------------------------------------------------
`include "stable_counting_sort_macros.svh"

module scs_ctrl import scs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_PFX,
      ST_PL_ITEM,
      ST_PL_CNT,
      ST_PL_WR,
      ST_EM_RD,
      ST_EM_SHOW
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      req_stall_in;
   logic      accept;

   assign accept = req_valid && !req_stall_ff;

   always_comb begin
      cmd          = '0;
      cmd.cnt_src  = CNT_SRC_LOAD;
      state_in     = state_ff;
      req_stall_in = req_stall_ff;
      case (state_ff)
         ST_LOAD: begin
            cmd.item_accept = accept;
            if (accept && req_last) begin
               state_in     = ST_DRAIN;
               req_stall_in = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (sts.held_zero) begin
               cmd.clear_batch = 1'b1;
               state_in        = ST_LOAD;
               req_stall_in    = 1'b0;
            end else begin
               cmd.pfx_start = 1'b1;
               state_in      = ST_PFX;
            end
         end
         ST_PFX: begin
            cmd.cnt_src = CNT_SRC_PFX;
            cmd.pfx_run = 1'b1;
            if (sts.pfx_done) begin
               state_in = ST_PL_ITEM;
            end
         end
         ST_PL_ITEM: begin
            cmd.cnt_src       = CNT_SRC_PLACE;
            cmd.place_item_rd = 1'b1;
            state_in          = ST_PL_CNT;
         end
         ST_PL_CNT: begin
            cmd.cnt_src = CNT_SRC_PLACE;
            state_in    = ST_PL_WR;
         end
         ST_PL_WR: begin
            cmd.cnt_src  = CNT_SRC_PLACE;
            cmd.place_wr = 1'b1;
            state_in     = sts.place_last ? ST_EM_RD : ST_PL_ITEM;
         end
         ST_EM_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EM_SHOW;
         end
         ST_EM_SHOW: begin
            if (!sts.rsp_busy) begin
               cmd.emit_load = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear_batch = 1'b1;
                  state_in        = ST_LOAD;
                  req_stall_in    = 1'b0;
               end else begin
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in     = ST_LOAD;
            req_stall_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

   `SCS_ASSERT_NEXT(a_last_stalls, clock, reset, cmd.item_accept && req_last, req_stall_ff, "input open after batch end")
   `SCS_ASSERT_NEXT(a_batch_reopens, clock, reset, cmd.clear_batch, !req_stall_ff, "input not reopened after batch")
   `SCS_ASSERT_NEXT(a_pfx_follows, clock, reset, cmd.pfx_start, cmd.pfx_run, "prefix pass did not start")

endmodule

// ===== sv/stable_counting_sort.sv =====
// ----------------------------------------------------------------------------
// Stable counting sort
// Collects a batch of keyed items and returns them in ascending key order.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Direction   Carries
//   req       req_valid/req_stall/req_data   in          one item per beat
//   rsp       rsp_valid/rsp_stall/rsp_data   out         one sorted item per beat
//   csr       csr_wr_en/csr_wr_data          in          key_range register
//
// Items are taken one per cycle while a batch loads. After the beat that marks
// the end of a batch, the input stalls while the sorter drains the count
// update, runs the prefix sum over the 64-entry count memory, places each item
// on the single read port of the item and count memories (item read, count
// read, then write), and returns each result with a read and a load of the
// output register. Stalls on rsp lengthen the return of results. A batch that
// ends with nothing held stalls the input only for the drain step.
// Reset is synchronous; the count memory needs no clearing pass because each
// entry has a valid bit; all valid bits clear together at reset and batch end.
//
// The sort is stable: the prefix pass turns per-key counts into start
// positions, and items are placed in arrival order, each taking the next slot
// of its key. A key at or above the effective range (key_range, capped at 64)
// is dropped and flagged on every result of its batch. Items beyond 64 in one
// batch are dropped silently. A batch that ends with nothing stored returns no
// result at all.
// ----------------------------------------------------------------------------
module stable_counting_sort import scs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [RANGE_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   // The controller only sequences; all storage sits in the datapath.
   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.batch_last),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   scs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== tb/stable_counting_sort_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stable counting sort testbench
// Sends batches of keyed items through the sorter and checks every sorted
// beat against a predictor kept in step with each accepted input beat. The
// key range is changed between phases while the sorter is idle.
// ----------------------------------------------------------------------------
module stable_counting_sort_test;
   import scs_pkg::*;

   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASES        = 8;

   typedef struct {
      req_type     beat;
      int unsigned gap;
   } queued_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [RANGE_W-1:0] csr_wr_data = RANGE_RESET;

   // Items waiting to be driven, and sorted beats waiting to come back.
   queued_item_type pending_items [$];
   rsp_type         sorted_expect [$];

   // Predictor state: a copy of the register and of the batch being collected.
   logic [RANGE_W-1:0] key_range_model = RANGE_RESET;
   logic [KEY_W-1:0]   held_key [MAX_ITEMS];
   logic [PAYLOAD_W-1:0] held_payload [MAX_ITEMS];
   int unsigned        key_tally [MAX_KEYS];
   int unsigned        held_count = 0;
   logic               batch_bad = 1'b0;

   // When set, neither side inserts idle cycles.
   logic calm = 1'b0;

   int errors = 0;
   int items_queued = 0;
   int items_sent = 0;
   int batches_closed = 0;
   int results_checked = 0;
   int settings_used = 0;
   int cycles = 0;

   logic [RANGE_W-1:0] phase_range [PHASES] = '{64, 1, 127, 0, 33, 65, 2, 40};
   int                 phase_items [PHASES] = '{70, 40, 70, 10, 40, 40, 30, 40};

   stable_counting_sort i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned draw_wait();
      if (calm || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 10);
   endfunction

   // Takes one accepted item into the predicted batch. On the last beat of a
   // batch the counts become end positions, the held items are placed from
   // newest to oldest, and the sorted batch is queued as expected beats.
   task automatic collect_and_sort(input req_type beat);
      int unsigned eff_range;
      int unsigned pos;
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] slot_key [MAX_ITEMS];
      logic [PAYLOAD_W-1:0] slot_payload [MAX_ITEMS];
      rsp_type r;
      eff_range = (key_range_model > MAX_KEYS) ? MAX_KEYS : key_range_model;
      if (beat.sort_key >= eff_range) begin
         batch_bad = 1'b1;
      end else if (held_count < MAX_ITEMS) begin
         held_key[held_count] = beat.sort_key;
         held_payload[held_count] = beat.payload;
         key_tally[beat.sort_key]++;
         held_count++;
      end
      if (beat.batch_last) begin
         batches_closed++;
         for (int i = 1; i < MAX_KEYS; i++)
            key_tally[i] += key_tally[i-1];
         for (int i = held_count; i > 0; i--) begin
            k = held_key[i-1];
            pos = key_tally[k] - 1;
            key_tally[k] = pos;
            slot_key[pos] = k;
            slot_payload[pos] = held_payload[i-1];
         end
         for (int i = 0; i < held_count; i++) begin
            r.out_key = slot_key[i];
            r.out_payload = slot_payload[i];
            r.out_last = (i + 1 == held_count);
            r.bad_key_seen = batch_bad;
            sorted_expect = {sorted_expect, r};
         end
         for (int i = 0; i < MAX_KEYS; i++)
            key_tally[i] = 0;
         held_count = 0;
         batch_bad = 1'b0;
      end
   endtask

   // Input driver. A presented beat holds until it is accepted; between beats
   // the driver waits the gap that was drawn for the next item.
   always @(posedge clock) begin : drive_items
      logic fire;
      int unsigned gap_count;
      queued_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            collect_and_sort(req_data);
            items_sent++;
         end
         if (req_valid && !fire) begin
            // Stalled: the beat stays on the bus unchanged.
         end else if (pending_items.size() != 0 && gap_count >= pending_items[0].gap) begin
            next_item = pending_items.pop_front();
            req_data <= next_item.beat;
            req_valid <= 1'b1;
            gap_count = 0;
         end else begin
            req_valid <= 1'b0;
            if (pending_items.size() != 0)
               gap_count++;
         end
      end
   end

   // Result monitor. The stall drawn after each beat counts down only while
   // a result is offered, so every drawn stall really holds one back.
   always @(posedge clock) begin : check_results
      rsp_type want;
      int unsigned stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_expect.size() == 0) begin
               $error("unexpected sorted beat: key %0d payload %h",
                      rsp_data.out_key, rsp_data.out_payload);
               errors++;
            end else begin
               want = sorted_expect.pop_front();
               results_checked++;
               if (rsp_data.out_key !== want.out_key) begin
                  $error("out_key: expected %0d, actual %0d",
                         want.out_key, rsp_data.out_key);
                  errors++;
               end
               if (rsp_data.out_payload !== want.out_payload) begin
                  $error("out_payload: expected %h, actual %h",
                         want.out_payload, rsp_data.out_payload);
                  errors++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last: expected %0b, actual %0b",
                         want.out_last, rsp_data.out_last);
                  errors++;
               end
               if (rsp_data.bad_key_seen !== want.bad_key_seen) begin
                  $error("bad_key_seen: expected %0b, actual %0b",
                         want.bad_key_seen, rsp_data.bad_key_seen);
                  errors++;
               end
            end
            stall_left = draw_wait();
         end else if (rsp_valid && stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_item(input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] p,
                             input logic last);
      queued_item_type q;
      q.beat.sort_key = k;
      q.beat.payload = p;
      q.beat.batch_last = last;
      q.gap = draw_wait();
      pending_items = {pending_items, q};
      items_queued++;
   endtask

   // One random batch. Most keys fall inside the range; a few are drawn from
   // the whole field so that some get dropped. Some batches use only a
   // handful of keys to pile up duplicates, and a forced batch overflows.
   task automatic queue_random_batch(input logic [RANGE_W-1:0] range, input logic overflow,
                                     output int n);
      int unsigned eff_range;
      int unsigned sel;
      logic narrow;
      logic [KEY_W-1:0] k;
      eff_range = (range > MAX_KEYS) ? MAX_KEYS : range;
      sel = $urandom_range(0, 19);
      if (overflow || sel == 0)
         n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
      else if (sel < 4)
         n = $urandom_range(33, MAX_ITEMS);
      else
         n = $urandom_range(1, 12);
      narrow = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         if (eff_range == 0 || $urandom_range(0, 7) == 0)
            k = KEY_W'($urandom_range(0, MAX_KEYS - 1));
         else if (narrow)
            k = KEY_W'($urandom_range(0, (eff_range < 4) ? eff_range - 1 : 3));
         else
            k = KEY_W'($urandom_range(0, eff_range - 1));
         queue_item(k, {$urandom, $urandom}, i == n - 1);
      end
   endtask

   // Waits until every queued item is taken and every sorted beat is back,
   // then leaves time for a batch that ended empty to finish its passes.
   task automatic wait_idle();
      while (items_sent != items_queued || sorted_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_range(input logic [RANGE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      key_range_model = value;
      settings_used++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int queued;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset range: field extremes, then equal keys
      // out of order to show that the sort keeps arrival order.
      queue_item(0, '0, 1'b1);
      queue_item(63, '1, 1'b1);
      queue_item(5, 64'd1, 1'b0);
      queue_item(3, 64'd2, 1'b0);
      queue_item(5, 64'd3, 1'b0);
      queue_item(0, 64'd4, 1'b0);
      queue_item(3, 64'd5, 1'b1);
      queue_item(63, 64'h8000_0000_0000_0000, 1'b0);
      queue_item(0, 64'h1, 1'b1);
      wait_idle();

      // Dropped keys flag the whole batch; a batch of only dropped keys
      // returns nothing.
      write_key_range(10);
      queue_item(12, 64'hdead_beef_0000_0001, 1'b0);
      queue_item(2, 64'h0123_4567_89ab_cdef, 1'b0);
      queue_item(9, 64'hfedc_ba98_7654_3210, 1'b0);
      queue_item(10, 64'h5555_aaaa_5555_aaaa, 1'b1);
      queue_item(40, 64'h1111_2222_3333_4444, 1'b1);
      wait_idle();

      // A zero range drops every key.
      write_key_range(0);
      queue_item(0, 64'haaaa_5555_aaaa_5555, 1'b0);
      queue_item(5, 64'h7, 1'b1);
      wait_idle();

      // A range above capacity acts as the full key space.
      write_key_range(127);
      queue_item(63, 64'h9, 1'b0);
      queue_item(62, 64'ha, 1'b1);
      wait_idle();

      // Random phases, each under its own range setting.
      phase_range[PHASES-1] = RANGE_W'($urandom_range(3, 64));
      for (int p = 0; p < PHASES; p++) begin
         write_key_range(phase_range[p]);
         queued = 0;
         while (queued < phase_items[p]) begin
            calm = ($urandom_range(0, 4) == 0);
            queue_random_batch(phase_range[p], queued == 0 && (p == 0 || p == 2), n);
            queued += n;
         end
         wait_idle();
      end
      calm = 1'b0;

      $display("Drove %0d item beats in %0d batches under %0d key range settings,",
               items_sent, batches_closed, settings_used);
      $display("with dropped keys, overflowing and empty batches; %0d sorted beats checked.",
               results_checked);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/scs_pkg.sv
sv/scs_datapath.sv
sv/scs_ctrl.sv
sv/stable_counting_sort.sv
tb/stable_counting_sort_test.sv
